// File: design/order_flow_window_stats_unit_macros.svh
// Assertion macros for the order flow window statistics unit.
// Included by the top level only; no other dependencies.
`ifndef ORDER_FLOW_WINDOW_STATS_UNIT_MACROS_SVH
`define ORDER_FLOW_WINDOW_STATS_UNIT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define OFW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must hold on every clock edge, reset included.
`define OFW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/ofws_pkg.sv
// Shared types and constants for the order flow window statistics unit.
// No dependencies.
package ofws_pkg;
   localparam int PRICE_BITS  = 24;
   localparam int VOLUME_BITS = 20;
   localparam int SUM_BITS    = 31;
   localparam int QUO_BITS    = 40;
   localparam int DEN_BITS    = 32;
   localparam int DIV_CNT_BITS = 6;

   // Division jobs, in issue order.
   typedef enum logic [2:0] {
      DIV_DELTA   = 3'd0,
      DIV_ASK_AVG = 3'd1,
      DIV_BID_AVG = 3'd2,
      DIV_DENSITY = 3'd3,
      DIV_NORM    = 3'd4
   } div_sel_type;

   localparam div_sel_type DIV_LAST = DIV_NORM;

   // Controller to datapath.
   typedef struct packed {
      logic        take;       // load and apply one record
      logic        div_start;  // start the division chosen by div_sel
      div_sel_type div_sel;
      logic        div_store;  // store the finished quotient
      logic        finish;     // record peak volume, clear window state
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic div_done;
   } sts_type;
endpackage

// File: design/ofws_if.sv
// Valid/ready channel carrying one payload.
// Depends on nothing; payload type set at instantiation.
interface ofws_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/order_flow_window_stats_unit.sv
// Order flow window statistics unit: each accepted record is applied directly
// to the window state (ready is high whenever the block is idle). The window's
// last record starts five divisions in turn on one shared radix-2 divider, and
// input is held off until the result transfer completes. Depends on ofws_pkg,
// ofws_ctrl and ofws_datapath.
`include "order_flow_window_stats_unit_macros.svh"
module order_flow_window_stats_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_record_kind,
   input  logic [ofws_pkg::PRICE_BITS-1:0]  req_price_ticks,
   input  logic [ofws_pkg::VOLUME_BITS-1:0] req_trade_volume,
   input  logic        req_last_in_window,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [24:0] rsp_delta_ratio,
   output logic signed [32:0] rsp_imbalance,
   output logic [31:0] rsp_ask_tick_avg,
   output logic [31:0] rsp_bid_tick_avg,
   output logic [31:0] rsp_range_density,
   output logic [23:0] rsp_range_ticks,
   output logic signed [24:0] rsp_net_ticks,
   output logic signed [1:0]  rsp_rotation_side,
   output logic signed [24:0] rsp_rotation_start,
   output logic signed [24:0] rsp_rotation_length,
   output logic [8:0]  rsp_volume_norm,
   output logic [31:0] rsp_total_volume,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import ofws_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [15:0] min_rot_ff;
   logic        last_take;

   // Configuration register, always ready.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) min_rot_ff <= 16'd1;
      else if (csr_valid) min_rot_ff <= csr_data;
   end

   ofws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_last   (req_last_in_window),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ofws_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .min_rot        (min_rot_ff),
      .kind           (req_record_kind),
      .price          (req_price_ticks),
      .volume         (req_trade_volume),
      .delta_ratio    (rsp_delta_ratio),
      .imbalance      (rsp_imbalance),
      .ask_avg        (rsp_ask_tick_avg),
      .bid_avg        (rsp_bid_tick_avg),
      .vol_density    (rsp_range_density),
      .range_ticks    (rsp_range_ticks),
      .px_move        (rsp_net_ticks),
      .rotation_side  (rsp_rotation_side),
      .rotation_start (rsp_rotation_start),
      .rot_span       (rsp_rotation_length),
      .volume_norm    (rsp_volume_norm),
      .total_volume   (rsp_total_volume)
   );

   assign last_take = req_valid && req_ready && req_last_in_window;

   `OFW_ASSERT(a_no_take_while_pending, clock, reset, !(rsp_valid && req_ready), "ready during result")
   `OFW_ASSERT(a_rsp_after_last, clock, reset, last_take |=> !req_ready, "intake not stopped")
   `OFW_ASSERT(a_side_valid, clock, reset, rsp_rotation_side != 2'sb10, "bad rotation side")
endmodule

// File: design/ofws_ctrl.sv
// Controller of the order flow window statistics unit.
// Depends on ofws_pkg.
module ofws_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_last,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output ofws_pkg::cmd_type cmd,
   input  ofws_pkg::sts_type sts
);
   import ofws_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   div_sel_type sel_ff, sel_in;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);

   // Sequence record intake, five divisions and the result transfer.
   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      cmd           = '0;
      cmd.div_sel   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.take = 1'b1;
               if (in_last) begin
                  state_in = ST_DIV;
                  sel_in   = DIV_DELTA;
               end
            end
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               if (sel_ff == DIV_LAST) begin
                  state_in = ST_OUT;
               end else begin
                  sel_in   = div_sel_type'(sel_ff + 3'd1);
                  state_in = ST_DIV;
               end
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= DIV_DELTA;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end
endmodule

// File: design/ofws_divider.sv
// Radix-2 restoring divider shared by all result divisions.
// Depends on ofws_pkg.
module ofws_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ofws_pkg::QUO_BITS-1:0] dividend,
   input  logic [ofws_pkg::DEN_BITS-1:0] divisor,
   output logic                          done,
   output logic [ofws_pkg::QUO_BITS-1:0] quotient
);
   import ofws_pkg::*;

   logic [QUO_BITS-1:0]     quo_ff, quo_in;
   logic [DEN_BITS-1:0]     rem_ff, rem_in;
   logic [DEN_BITS-1:0]     den_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in, done_ff, done_in;
   logic [DEN_BITS:0]       trial;

   // One quotient bit per cycle, most significant first.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[QUO_BITS-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = DIV_CNT_BITS'(QUO_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_BITS'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_BITS-1:0];
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) den_ff <= divisor;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: design/ofws_datapath.sv
// Datapath: window accumulators, rotation tracking and result assembly.
// Depends on ofws_pkg and ofws_divider.
module ofws_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ofws_pkg::cmd_type                cmd,
   output ofws_pkg::sts_type                sts,
   input  logic [15:0]                      min_rot,
   input  logic [1:0]                       kind,
   input  logic [ofws_pkg::PRICE_BITS-1:0]  price,
   input  logic [ofws_pkg::VOLUME_BITS-1:0] volume,
   output logic signed [24:0]               delta_ratio,
   output logic signed [32:0]               imbalance,
   output logic [31:0]                      ask_avg,
   output logic [31:0]                      bid_avg,
   output logic [31:0]                      vol_density,
   output logic [23:0]                      range_ticks,
   output logic signed [24:0]               px_move,
   output logic signed [1:0]                rotation_side,
   output logic signed [24:0]               rotation_start,
   output logic signed [24:0]               rot_span,
   output logic [8:0]                       volume_norm,
   output logic [31:0]                      total_volume
);
   import ofws_pkg::*;

   localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
   localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

   logic [SUM_BITS-1:0]   bid_sum_ff, ask_sum_ff;
   logic [31:0]           bid_tick_ff, ask_tick_ff, peak_ff;
   logic [PRICE_BITS-1:0] first_ff, last_ff, prev_bid_ff, prev_ask_ff;
   logic [PRICE_BITS-1:0] high_ff, low_ff, sw_high_ff, sw_low_ff;
   logic                  seen_ff;
   logic signed [24:0]    exc_ff;
   logic signed [1:0]     side_ff;

   logic [SUM_BITS-1:0]   bid_sum_in, ask_sum_in;
   logic [31:0]           bid_tick_in, ask_tick_in;
   logic [PRICE_BITS-1:0] first_in, last_in, prev_bid_in, prev_ask_in;
   logic [PRICE_BITS-1:0] high_in, low_in, sw_high_in, sw_low_in;
   logic                  seen_in;
   logic signed [24:0]    exc_in;
   logic signed [1:0]     side_in;

   logic [SUM_BITS:0]     vsum;
   logic [32:0]           tsum;
   logic [PRICE_BITS-1:0] pb, pa, sh, sl, drop_hi, rise_lo;

   // Apply one non-quote record to the window and swing state.
   always_comb begin
      bid_sum_in  = bid_sum_ff;  ask_sum_in  = ask_sum_ff;
      bid_tick_in = bid_tick_ff; ask_tick_in = ask_tick_ff;
      first_in    = first_ff;    last_in     = last_ff;
      prev_bid_in = prev_bid_ff; prev_ask_in = prev_ask_ff;
      high_in     = high_ff;     low_in      = low_ff;
      sw_high_in  = sw_high_ff;  sw_low_in   = sw_low_ff;
      seen_in     = seen_ff;     exc_in      = exc_ff;
      side_in     = side_ff;
      vsum = '0; tsum = '0; drop_hi = '0; rise_lo = '0;
      pb = seen_ff ? prev_bid_ff : price;
      pa = seen_ff ? prev_ask_ff : price;
      sh = sw_high_ff; sl = sw_low_ff;
      if (cmd.take && kind != 2'd2) begin
         if (!seen_ff) begin
            first_in = price;
            seen_in  = 1'b1;
         end
         prev_bid_in = pb;
         prev_ask_in = pa;
         if (kind == 2'd0) begin
            vsum = {1'b0, bid_sum_ff} + (SUM_BITS+1)'(volume);
            bid_sum_in = vsum[SUM_BITS] ? SUM_MAX : vsum[SUM_BITS-1:0];
            last_in = price;
            if (price < low_ff) low_in = price;
            if (price < pb) begin
               tsum = {1'b0, bid_tick_ff} + 33'(pb - price);
               bid_tick_in = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
            end
            prev_bid_in = price;
         end else if (kind == 2'd1) begin
            vsum = {1'b0, ask_sum_ff} + (SUM_BITS+1)'(volume);
            ask_sum_in = vsum[SUM_BITS] ? SUM_MAX : vsum[SUM_BITS-1:0];
            last_in = price;
            if (price > high_ff) high_in = price;
            if (price > pa) begin
               tsum = {1'b0, ask_tick_ff} + 33'(price - pa);
               ask_tick_in = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
            end
            prev_ask_in = price;
         end
         if (price > sh) sh = price;
         if (price < sl) sl = price;
         drop_hi = sh - price;
         rise_lo = price - sl;
         if (32'(drop_hi) >= 32'(min_rot)) begin
            if (side_ff > -2'sd1) begin
               side_in = -2'sd1;
               sl      = price;
               rise_lo = '0;
            end
            if ($signed({1'b0, drop_hi}) > exc_ff) exc_in = $signed({1'b0, drop_hi});
         end
         if (32'(rise_lo) >= 32'(min_rot)) begin
            if (side_in < 2'sd1) begin
               side_in = 2'sd1;
               sh      = price;
            end
            if ($signed({1'b0, rise_lo}) > exc_in) exc_in = $signed({1'b0, rise_lo});
         end
         sw_high_in = sh;
         sw_low_in  = sl;
      end
   end

   // Window totals and division operands.
   logic [SUM_BITS:0]     vol_all;
   logic [31:0]           total;
   logic [31:0]           peak_now;
   logic                  has_range;
   logic [PRICE_BITS-1:0] range;
   logic [QUO_BITS-1:0]   dvd;
   logic [DEN_BITS-1:0]   dvs;
   logic                  div_done;
   logic [QUO_BITS-1:0]   quo;

   assign vol_all   = {1'b0, bid_sum_ff} + {1'b0, ask_sum_ff};
   assign total     = vol_all[31:0];
   assign peak_now  = (total > peak_ff) ? total : peak_ff;
   assign has_range = high_ff > low_ff;
   assign range     = high_ff - low_ff;

   // Zero divisors are replaced by one; the result is overridden on store.
   always_comb begin
      dvd = '0;
      dvs = 32'd1;
      case (cmd.div_sel)
         DIV_DELTA: begin
            dvd = QUO_BITS'({ask_sum_ff, 8'd0});
            dvs = (bid_sum_ff == '0) ? 32'd1 : 32'(bid_sum_ff);
         end
         DIV_ASK_AVG: begin
            dvd = QUO_BITS'(ask_sum_ff);
            dvs = (ask_tick_ff == '0) ? 32'd1 : ask_tick_ff;
         end
         DIV_BID_AVG: begin
            dvd = QUO_BITS'(bid_sum_ff);
            dvs = (bid_tick_ff == '0) ? 32'd1 : bid_tick_ff;
         end
         DIV_DENSITY: begin
            dvd = QUO_BITS'(vol_all);
            dvs = has_range ? 32'(range) : 32'd1;
         end
         DIV_NORM: begin
            dvd = QUO_BITS'({total, 8'd0});
            dvs = (peak_now == '0) ? 32'd1 : peak_now;
         end
         default: ;
      endcase
   end

   ofws_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo)
   );
   assign sts.div_done = div_done;

   // Result registers.
   logic signed [24:0] delta_ff;
   logic [31:0]        ask_avg_ff, bid_avg_ff, dens_ff;
   logic [8:0]         norm_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         case (cmd.div_sel)
            DIV_DELTA: begin
               if (bid_sum_ff == '0) delta_ff <= -25'sd256;
               else if (quo > QUO_BITS'(24'hFF_FFFF)) delta_ff <= 25'sh0FF_FFFF;
               else delta_ff <= $signed({1'b0, quo[23:0]});
            end
            DIV_ASK_AVG: ask_avg_ff <= (ask_tick_ff == '0) ? '0 : quo[31:0];
            DIV_BID_AVG: bid_avg_ff <= (bid_tick_ff == '0) ? '0 : quo[31:0];
            DIV_DENSITY: dens_ff    <= has_range ? quo[31:0] : '0;
            DIV_NORM:    norm_ff    <= (peak_now == '0) ? '0 : quo[8:0];
            default: ;
         endcase
      end
   end

   assign delta_ratio    = delta_ff;
   assign imbalance      = $signed(33'(ask_sum_ff)) - $signed(33'(bid_sum_ff));
   assign ask_avg        = ask_avg_ff;
   assign bid_avg        = bid_avg_ff;
   assign vol_density    = dens_ff;
   assign range_ticks    = has_range ? 24'(range) : '0;
   assign px_move        = $signed(25'(last_ff)) - $signed(25'(first_ff));
   assign rotation_side  = side_ff;
   assign rotation_start = (side_ff == 2'sd1)  ? $signed(25'(sw_low_ff)) :
                           (side_ff == -2'sd1) ? $signed(25'(sw_high_ff)) : -25'sd1;
   assign rot_span       = exc_ff;
   assign volume_norm    = norm_ff;
   assign total_volume   = total;

   // Update state; clear the window after the result transfer.
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         bid_sum_ff  <= '0;  ask_sum_ff  <= '0;
         bid_tick_ff <= '0;  ask_tick_ff <= '0;
         first_ff    <= '0;  last_ff     <= '0;
         prev_bid_ff <= '0;  prev_ask_ff <= '0;
         high_ff     <= '0;  low_ff      <= PRICE_MAX;
         seen_ff     <= 1'b0;
         exc_ff      <= -25'sd1;
      end else begin
         bid_sum_ff  <= bid_sum_in;  ask_sum_ff  <= ask_sum_in;
         bid_tick_ff <= bid_tick_in; ask_tick_ff <= ask_tick_in;
         first_ff    <= first_in;    last_ff     <= last_in;
         prev_bid_ff <= prev_bid_in; prev_ask_ff <= prev_ask_in;
         high_ff     <= high_in;     low_ff      <= low_in;
         seen_ff     <= seen_in;     exc_ff      <= exc_in;
      end
      if (reset) begin
         side_ff    <= '0;
         sw_high_ff <= '0;
         sw_low_ff  <= PRICE_MAX;
         peak_ff    <= '0;
      end else begin
         side_ff    <= side_in;
         sw_high_ff <= sw_high_in;
         sw_low_ff  <= sw_low_in;
         if (cmd.finish) peak_ff <= peak_now;
      end
   end
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for order_flow_window_stats_unit.
// Depends on ofws_pkg, ofws_if and the design top; drives records, checks each
// window result against an in-bench model of the window statistics.
`timescale 1ns / 1ps
module tb_top;
   import ofws_pkg::*;

   typedef enum logic [1:0] {
      KIND_BID   = 2'd0,
      KIND_ASK   = 2'd1,
      KIND_QUOTE = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [PRICE_BITS-1:0]  price;
      logic [VOLUME_BITS-1:0] vol;
      logic                   last;
   } record_type;

   typedef struct packed {
      logic signed [24:0] delta_ratio;
      logic signed [32:0] imbalance;
      logic [31:0]        ask_avg;
      logic [31:0]        bid_avg;
      logic [31:0]        vol_density;
      logic [23:0]        range_ticks;
      logic signed [24:0] px_move;
      logic signed [1:0]  rotation_side;
      logic signed [24:0] rotation_start;
      logic signed [24:0] rot_span;
      logic [8:0]         volume_norm;
      logic [31:0]        total_volume;
   } stats_type;

   typedef struct {
      record_type rec;
      bit         has_typed;
      stats_type  typed;
   } stim_row_type;

   localparam longint PRICE_ONES = 64'hFF_FFFF;
   localparam longint SUM_ONES   = 64'h7FFF_FFFF;
   localparam longint W32_ONES   = 64'hFFFF_FFFF;
   localparam int     IDLE_LIMIT = 20000;
   localparam int     DRAIN_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   bit   long_hold = 1'b0;

   ofws_if #(.payload_type(record_type))  req_ch ();
   ofws_if #(.payload_type(stats_type))   rsp_ch ();
   ofws_if #(.payload_type(logic [15:0])) csr_ch ();

   stats_type window_results_q[$];

   // model state
   longint unsigned rot_thresh;
   longint unsigned bid_vol, ask_vol, bid_tk_sum, ask_tk_sum;
   longint unsigned first_px, last_px, prev_bid_px, prev_ask_px, win_high, win_low;
   bit              first_seen;
   longint          excursion_max;
   int              swing_side;
   longint unsigned swing_high, swing_low, peak_volume;

   always #10 clock = ~clock;

   order_flow_window_stats_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_ch.valid),
      .req_ready           (req_ch.ready),
      .req_record_kind     (req_ch.data.kind),
      .req_price_ticks     (req_ch.data.price),
      .req_trade_volume    (req_ch.data.vol),
      .req_last_in_window  (req_ch.data.last),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_delta_ratio     (rsp_ch.data.delta_ratio),
      .rsp_imbalance       (rsp_ch.data.imbalance),
      .rsp_ask_tick_avg    (rsp_ch.data.ask_avg),
      .rsp_bid_tick_avg    (rsp_ch.data.bid_avg),
      .rsp_range_density   (rsp_ch.data.vol_density),
      .rsp_range_ticks     (rsp_ch.data.range_ticks),
      .rsp_net_ticks       (rsp_ch.data.px_move),
      .rsp_rotation_side   (rsp_ch.data.rotation_side),
      .rsp_rotation_start  (rsp_ch.data.rotation_start),
      .rsp_rotation_length (rsp_ch.data.rot_span),
      .rsp_volume_norm     (rsp_ch.data.volume_norm),
      .rsp_total_volume    (rsp_ch.data.total_volume),
      .csr_valid           (csr_ch.valid),
      .csr_ready           (csr_ch.ready),
      .csr_data            (csr_ch.data)
   );

   function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                               longint unsigned lim);
      longint unsigned s;
      s = a + b;
      return (s > lim) ? lim : s;
   endfunction

   function automatic void clear_window_stats();
      bid_vol = 0; ask_vol = 0; bid_tk_sum = 0; ask_tk_sum = 0;
      first_px = 0; last_px = 0; prev_bid_px = 0; prev_ask_px = 0;
      win_high = 0; win_low = PRICE_ONES;
      first_seen = 0;
      excursion_max = -1;
   endfunction

   // Apply one record to the window model; return 1 with the stats on window end.
   function automatic bit apply_record(record_type r, output stats_type o);
      longint unsigned p, v, drop_hi, rise_lo, total, delta, aavg, bavg, span, dens, norm;
      longint          start;
      o = '0;
      p = r.price;
      v = r.vol;
      if (r.kind != KIND_QUOTE) begin
         if (!first_seen) begin
            first_px = p; prev_bid_px = p; prev_ask_px = p;
            first_seen = 1;
         end
         if (r.kind == KIND_BID) begin
            bid_vol = sat_sum(bid_vol, v, SUM_ONES);
            last_px = p;
            if (p < win_low) win_low = p;
            if (p < prev_bid_px) bid_tk_sum = sat_sum(bid_tk_sum, prev_bid_px - p, W32_ONES);
            prev_bid_px = p;
         end else if (r.kind == KIND_ASK) begin
            ask_vol = sat_sum(ask_vol, v, SUM_ONES);
            last_px = p;
            if (p > win_high) win_high = p;
            if (p > prev_ask_px) ask_tk_sum = sat_sum(ask_tk_sum, p - prev_ask_px, W32_ONES);
            prev_ask_px = p;
         end
         // track swings; the down step is checked before the up step
         if (p > swing_high) swing_high = p;
         if (p < swing_low) swing_low = p;
         drop_hi = swing_high - p;
         rise_lo = p - swing_low;
         if (drop_hi >= rot_thresh) begin
            if (swing_side > -1) begin
               swing_side = -1; swing_low = p; rise_lo = 0;
            end
            if (longint'(drop_hi) > excursion_max) excursion_max = drop_hi;
         end
         if (rise_lo >= rot_thresh) begin
            if (swing_side < 1) begin
               swing_side = 1; swing_high = p;
            end
            if (longint'(rise_lo) > excursion_max) excursion_max = rise_lo;
         end
      end
      if (!r.last) return 0;

      total = sat_sum(bid_vol, ask_vol, W32_ONES);
      aavg = 0; bavg = 0; span = 0; dens = 0; norm = 0;
      if (bid_vol > 0) begin
         delta = (ask_vol * 256) / bid_vol;
         if (delta > 64'hFF_FFFF) delta = 64'hFF_FFFF;
      end else begin
         delta = -256;
      end
      if (total > peak_volume) peak_volume = total;
      if (peak_volume > 0) norm = (total * 256) / peak_volume;
      if (ask_tk_sum > 0) aavg = ask_vol / ask_tk_sum;
      if (bid_tk_sum > 0) bavg = bid_vol / bid_tk_sum;
      if (win_high > win_low) begin
         span = win_high - win_low;
         dens = (bid_vol + ask_vol) / span;
         if (dens > W32_ONES) dens = W32_ONES;
      end
      start = (swing_side == 1) ? longint'(swing_low) :
              (swing_side == -1) ? longint'(swing_high) : -1;
      o.delta_ratio    = delta[24:0];
      o.imbalance      = 33'(ask_vol - bid_vol);
      o.ask_avg        = aavg[31:0];
      o.bid_avg        = bavg[31:0];
      o.vol_density    = dens[31:0];
      o.range_ticks    = span[23:0];
      o.px_move        = 25'(last_px - first_px);
      o.rotation_side  = 2'(swing_side);
      o.rotation_start = 25'(start);
      o.rot_span       = 25'(excursion_max);
      o.volume_norm    = norm[8:0];
      o.total_volume   = total[31:0];
      clear_window_stats();
      return 1;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   task automatic compare_stats(string tag, stats_type e, stats_type a);
      check_field({tag, "delta"}, e.delta_ratio, a.delta_ratio);
      check_field({tag, "imbalance"}, e.imbalance, a.imbalance);
      check_field({tag, "ask average"}, e.ask_avg, a.ask_avg);
      check_field({tag, "bid average"}, e.bid_avg, a.bid_avg);
      check_field({tag, "density"}, e.vol_density, a.vol_density);
      check_field({tag, "range"}, e.range_ticks, a.range_ticks);
      check_field({tag, "net move"}, e.px_move, a.px_move);
      check_field({tag, "rotation side"}, e.rotation_side, a.rotation_side);
      check_field({tag, "rotation start"}, e.rotation_start, a.rotation_start);
      check_field({tag, "rotation span"}, e.rot_span, a.rot_span);
      check_field({tag, "volume norm"}, e.volume_norm, a.volume_norm);
      check_field({tag, "total volume"}, e.total_volume, a.total_volume);
   endtask

   // sender burst state
   int burst_left = 0;
   bit no_gaps = 0;

   // Offer one record and hold it until the transfer; predict on acceptance.
   task automatic send_record(record_type r, bit has_typed = 0,
                              stats_type typed = '0);
      stats_type o;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = no_gaps ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
      if (apply_record(r, o)) begin
         if (has_typed) compare_stats("typed ", typed, o);
         window_results_q.push_back(o);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (window_results_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write the rotation threshold while the block is idle.
   task automatic write_rot_thresh(logic [15:0] val);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      rot_thresh = val;
   endtask

   function automatic record_type make_record(kind_type k, int unsigned px,
                                              int unsigned vol, bit last);
      record_type r;
      r.kind = k; r.price = PRICE_BITS'(px); r.vol = VOLUME_BITS'(vol); r.last = last;
      return r;
   endfunction

   // random walk state for well-formed windows
   int unsigned walk_px = 24'h40_0000;
   int unsigned walk_step = 3;

   function automatic record_type random_record(bit force_last);
      record_type r;
      int unsigned sel, delta;
      sel = $urandom_range(0, 9);
      r.kind = (sel < 4) ? KIND_BID : (sel < 8) ? KIND_ASK :
               (sel == 8) ? KIND_QUOTE : KIND_OTHER;
      if ($urandom_range(0, 9) == 0) begin
         r.price = PRICE_BITS'($urandom);
      end else begin
         delta = $urandom_range(0, 2 * walk_step);
         walk_px = walk_px + delta - walk_step;
         if (walk_px > PRICE_ONES) walk_px = 24'h40_0000;
         r.price = PRICE_BITS'(walk_px);
      end
      r.vol = ($urandom_range(0, 9) < 7) ? VOLUME_BITS'($urandom_range(0, 1000)) :
                                           VOLUME_BITS'($urandom);
      r.last = force_last || ($urandom_range(0, 6) == 0);
      if (r.last && $urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0: walk_step = 1;
            1: walk_step = 3;
            2: walk_step = 40;
            default: walk_step = 600;
         endcase
      end
      return r;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         send_record(random_record(i == count - 1));
      end
   endtask

   // Main stimulus
   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      rot_thresh = 1;
      clear_window_stats();
      swing_side = 0; swing_high = 0; swing_low = PRICE_ONES; peak_volume = 0;

      // quote that ends the window after reset: empty stats
      row.has_typed = 1;
      row.rec = make_record(KIND_QUOTE, 24'hFFFFFF, 20'hFFFFF, 1);
      row.typed = '0;
      row.typed.delta_ratio = -256;
      row.typed.rotation_start = -1;
      row.typed.rot_span = -1;
      rows.push_back(row);
      // lone bid trade at full volume
      row.rec = make_record(KIND_BID, 100, 20'hFFFFF, 1);
      row.typed = '0;
      row.typed.imbalance = -33'sd1048575;
      row.typed.rotation_start = -1;
      row.typed.rot_span = -1;
      row.typed.volume_norm = 256;
      row.typed.total_volume = 32'd1048575;
      rows.push_back(row);
      row.has_typed = 0;
      // extremes and every kind, then a window with no bid/ask trades
      rows.push_back('{make_record(KIND_ASK, 24'hFFFFFF, 0, 0), 0, '0});
      rows.push_back('{make_record(KIND_BID, 0, 20'hFFFFF, 0), 0, '0});
      rows.push_back('{make_record(KIND_OTHER, 24'h123456, 7, 0), 0, '0});
      rows.push_back('{make_record(KIND_QUOTE, 5, 5, 0), 0, '0});
      rows.push_back('{make_record(KIND_ASK, 24'h800000, 20'h55555, 1), 0, '0});
      rows.push_back('{make_record(KIND_OTHER, 24'h000300, 9, 0), 0, '0});
      rows.push_back('{make_record(KIND_OTHER, 24'h000100, 9, 1), 0, '0});
      rows.push_back('{make_record(KIND_BID, 1000, 10, 0), 0, '0});
      rows.push_back('{make_record(KIND_BID, 990, 20, 0), 0, '0});
      rows.push_back('{make_record(KIND_ASK, 995, 30, 0), 0, '0});
      rows.push_back('{make_record(KIND_ASK, 1010, 40, 0), 0, '0});
      rows.push_back('{make_record(KIND_BID, 1001, 20'hAAAAA, 1), 0, '0});
      rows.push_back('{make_record(KIND_QUOTE, 0, 0, 1), 0, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_record(rows[i].rec, rows[i].has_typed, rows[i].typed);

      // zero threshold: every trade qualifies both ways
      write_rot_thresh(16'd0);
      send_record(make_record(KIND_BID, 500, 1, 0));
      send_record(make_record(KIND_ASK, 505, 1, 0));
      send_record(make_record(KIND_OTHER, 498, 1, 1));
      random_phase(150);

      write_rot_thresh(16'hFFFF);
      random_phase(150);

      write_rot_thresh(16'($urandom_range(2, 60)));
      random_phase(150);

      // saturate both tick sums in one long window
      write_rot_thresh(16'd5);
      for (int i = 0; i < 1040; i++) begin
         case (i % 4)
            0: send_record(make_record(KIND_BID, 24'hFFFFFF, 20'hFFFFF, 0));
            1: send_record(make_record(KIND_BID, 0, 20'hFFFFF, 0));
            2: send_record(make_record(KIND_ASK, 0, 20'hFFFFF, 0));
            default: send_record(make_record(KIND_ASK, 24'hFFFFFF, 20'hFFFFF, i == 1039));
         endcase
      end

      write_rot_thresh(16'($urandom));
      random_phase(100);
      write_rot_thresh(16'd1);
      random_phase(100);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("** order_flow_window_stats_unit: PASSED **");
      end else begin
         $display("** order_flow_window_stats_unit: FAILED **");
      end
      $finish;
   end

   // Receiver: stall pattern redrawn at random from three modes
   int rx_mode = 0;
   int rx_count = 0;
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      rx_count <= rx_count + 1;
      if (rx_count % 64 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
         0: rsp_ch.ready <= !long_hold;
         1: rsp_ch.ready <= !long_hold && $urandom_range(0, 1);
         default: rsp_ch.ready <= !long_hold && ($urandom_range(0, 3) == 0);
      endcase
   end

   // Hold off the receiver for a long stretch while records keep coming
   initial begin
      repeat (3000) @(posedge clock);
      long_hold = 1'b1;
      repeat (800) @(posedge clock);
      long_hold = 1'b0;
   end

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (window_results_q.size() == 0) begin
            $display("%0t: unexpected result, actual %0h", $time, rsp_ch.data);
            errors++;
         end else begin
            compare_stats("", window_results_q.pop_front(), rsp_ch.data);
         end
      end
   end

   // Watchdog on cycles without any transfer
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  window_results_q.size());
         $display("** order_flow_window_stats_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end
endmodule
